// ----- rtl/btkpq_pkg.sv -----
// Package for the bounded top-k priority queue: sizes, codes, cell commands,
// control state and the control struct that drives the cell row.
// No dependencies.
package btkpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CAP_W      = 7;
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int OUT_KEY_W  = 32;
  localparam int FILL_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SMALLEST = 1'd1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_HOLD
  } state_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic [KEY_W-1:0]       key;
    logic [CNT_W-1:0]       count;
  } row_ctl_t;

endpackage

// ----- rtl/btkpq_if.sv -----
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on btkpq_pkg.
interface btkpq_in_if import btkpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    key_value;

  modport source (output valid, output kind, output key_value, input ready);
  modport sink   (input valid, input kind, input key_value, output ready);
endinterface

interface btkpq_out_if import btkpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [OUT_KEY_W-1:0] out_key;
  logic [FILL_W-1:0]    fill;

  modport source (output valid, output status, output out_key, output fill, input ready);
  modport sink   (input valid, input status, input out_key, input fill, output ready);
endinterface

interface btkpq_cfg_if import btkpq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/btkpq_cell.sv -----
// One cell of the sorted key row: holds one key, inserts or shifts left.
// Depends on btkpq_pkg.
module btkpq_cell import btkpq_pkg::*; (
  input  logic             clk,
  input  row_ctl_t         ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic [KEY_W-1:0] left_key,
  input  logic             left_ins,
  input  logic [KEY_W-1:0] right_key,
  output logic [KEY_W-1:0] key,
  output logic             ins,
  output logic [KEY_W-1:0] last_key
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             occupied;
  logic             is_last;

  assign occupied = CNT_W'(idx) < ctl.count;
  assign is_last  = (CNT_W'(idx) + CNT_W'(1)) == ctl.count;
  assign ins      = !occupied || (ctl.key < key_r);
  assign key      = key_r;
  assign last_key = is_last ? key_r : '0;

  always_comb begin
    key_nxt = key_r;
    case (ctl.cmd)
      CELL_INSERT: begin
        if (ins) begin
          key_nxt = left_ins ? left_key : ctl.key;
        end
      end
      CELL_SHIFT: key_nxt = right_key;
      default:    key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- rtl/btkpq_row.sv -----
// Row of cells holding the keys in ascending order from cell 0.
// Depends on btkpq_pkg, btkpq_cell.
module btkpq_row import btkpq_pkg::*; (
  input  logic             clk,
  input  row_ctl_t         ctl,
  output logic [KEY_W-1:0] low_key,
  output logic [KEY_W-1:0] high_key
);

  logic [KEY_W-1:0] key_w  [CAPACITY];
  logic [KEY_W-1:0] last_w [CAPACITY];
  logic             ins_w  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] lk;
    logic             li;
    logic [KEY_W-1:0] rk;

    if (i == 0) begin : g_first
      assign lk = '0;
      assign li = 1'b0;
    end else begin : g_mid
      assign lk = key_w[i-1];
      assign li = ins_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = key_w[i];
    end else begin : g_inner
      assign rk = key_w[i+1];
    end

    btkpq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (IDX_W'(i)),
      .left_key (lk),
      .left_ins (li),
      .right_key(rk),
      .key      (key_w[i]),
      .ins      (ins_w[i]),
      .last_key (last_w[i])
    );
  end

  assign low_key = key_w[0];

  always_comb begin
    high_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      high_key = high_key | last_w[i];
    end
  end

endmodule

// ----- rtl/btkpq_ctrl.sv -----
// Sequencer: config registers, fill count, item decode, result register.
// Depends on btkpq_pkg, btkpq_if.
module btkpq_ctrl import btkpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  btkpq_cfg_if.sink         cfg,
  btkpq_in_if.sink          in_b,
  btkpq_out_if.source       out_b,
  input  logic [KEY_W-1:0]  low_key,
  input  logic [KEY_W-1:0]  high_key,
  output row_ctl_t          ctl
);

  state_t                state_r, state_nxt;
  logic [CAP_W-1:0]      capacity_r;
  logic                  keep_small_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [KEY_W-1:0]      key_r;
  logic [STATUS_W-1:0]   hold_status_r;
  logic [KEY_W-1:0]      hold_key_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [OUT_KEY_W-1:0]  out_key_r;
  logic [FILL_W-1:0]     out_fill_r;

  logic [CMP_W-1:0]      cap_ext, limit, count_ext;
  logic [KEY_W-1:0]      front_key;
  logic                  full, beats, out_free;
  logic                  evict, done, load_out, save_hold;
  logic [STATUS_W-1:0]   res_status;
  logic [KEY_W-1:0]      res_key;
  cell_cmd_t             cmd;

  assign cap_ext   = CMP_W'(capacity_r);
  assign count_ext = CMP_W'(count_r);
  assign limit     = (cap_ext == '0) ? CMP_W'(1) :
                     (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
  assign full      = (count_ext >= limit) && (count_r != '0);
  assign front_key = keep_small_r ? high_key : low_key;
  assign beats     = keep_small_r ? (key_r < front_key) : (front_key < key_r);
  assign out_free  = !out_valid_r || out_b.ready;

  assign cfg.ready     = 1'b1;
  assign in_b.ready    = (state_r == S_IDLE);
  assign out_b.valid   = out_valid_r;
  assign out_b.status  = out_status_r;
  assign out_b.out_key = out_key_r;
  assign out_b.fill    = out_fill_r;

  assign ctl.cmd   = cmd;
  assign ctl.key   = key_r;
  assign ctl.count = count_r;

  // decode and cell commands
  always_comb begin
    cmd        = CELL_HOLD;
    count_nxt  = count_r;
    res_status = ST_DROPPED;
    res_key    = '0;
    evict      = 1'b0;
    done       = 1'b0;
    case (state_r)
      S_EXEC: begin
        case (kind_r)
          KIND_INSERT: begin
            if (full) begin
              if (beats) begin
                cmd       = keep_small_r ? CELL_HOLD : CELL_SHIFT;
                count_nxt = count_r - CNT_W'(1);
                evict     = 1'b1;
              end else begin
                done = 1'b1;
              end
            end else begin
              cmd        = CELL_INSERT;
              count_nxt  = count_r + CNT_W'(1);
              res_status = ST_INSERTED;
              done       = 1'b1;
            end
          end
          KIND_REMOVE: begin
            done = 1'b1;
            if (count_r == '0) begin
              res_status = ST_EMPTY;
            end else begin
              cmd        = keep_small_r ? CELL_HOLD : CELL_SHIFT;
              count_nxt  = count_r - CNT_W'(1);
              res_status = ST_REMOVED;
              res_key    = front_key;
            end
          end
          KIND_CLEAR: begin
            count_nxt  = '0;
            res_status = ST_CLEARED;
            done       = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
      S_PUSH: begin
        cmd        = CELL_INSERT;
        count_nxt  = count_r + CNT_W'(1);
        res_status = ST_EVICTED;
        res_key    = hold_key_r;
        done       = 1'b1;
      end
      default: cmd = CELL_HOLD;
    endcase
  end

  assign load_out  = (done || (state_r == S_HOLD)) && out_free;
  assign save_hold = done && !out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_b.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (evict) state_nxt = S_PUSH;
        else       state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_PUSH:  state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  state_nxt = out_free ? S_IDLE : S_HOLD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      capacity_r   <= CAP_W'(64);
      keep_small_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg.valid && (cfg.index == CFG_CAPACITY)) begin
        capacity_r <= cfg.data[CAP_W-1:0];
      end
      if (cfg.valid && (cfg.index == CFG_KEEP_SMALLEST)) begin
        keep_small_r <= cfg.data[0];
      end
      if (load_out)         out_valid_r <= 1'b1;
      else if (out_b.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_b.valid && in_b.ready) begin
      kind_r <= in_b.kind;
      key_r  <= in_b.key_value;
    end
    if (evict) begin
      hold_key_r <= front_key;
    end else if (save_hold) begin
      hold_key_r <= res_key;
    end
    if (save_hold) begin
      hold_status_r <= res_status;
    end
    if (load_out) begin
      if (state_r == S_HOLD) begin
        out_status_r <= hold_status_r;
        out_key_r    <= OUT_KEY_W'(hold_key_r);
        out_fill_r   <= FILL_W'(count_r);
      end else begin
        out_status_r <= res_status;
        out_key_r    <= OUT_KEY_W'(res_key);
        out_fill_r   <= FILL_W'(count_nxt);
      end
    end
  end

endmodule

// ----- rtl/bounded_top_k_priority_queue_unit.sv -----
// Top level of the bounded top-k priority queue: sequencer plus sorted cell row.
// Depends on btkpq_pkg, btkpq_if, btkpq_ctrl, btkpq_row.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    kind, key_value
//   out_ch   out  valid / ready    status, out_key, fill
//   cfg_ch   in   valid / ready    index, data (capacity, keep_smallest)
//
// Each item is accepted in S_IDLE and executed in the cell row in S_EXEC; an insert
// that evicts also passes S_PUSH (remove the front, then insert into the row).
// Every cell compares the new key in the same cycle; the row shifts one slot.
// Reset is synchronous; the fill count clears, cell contents are left as is.
// A result waiting on out_ch does not block the next accept; a second result
// waits in the sequencer until out_ch frees.
module bounded_top_k_priority_queue_unit import btkpq_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  btkpq_in_if.sink     in_ch,
  btkpq_out_if.source  out_ch,
  btkpq_cfg_if.sink    cfg_ch
);

  row_ctl_t         ctl;
  logic [KEY_W-1:0] low_key;
  logic [KEY_W-1:0] high_key;

  btkpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .in_b    (in_ch),
    .out_b   (out_ch),
    .low_key (low_key),
    .high_key(high_key),
    .ctl     (ctl)
  );

  btkpq_row u_row (
    .clk     (clk),
    .ctl     (ctl),
    .low_key (low_key),
    .high_key(high_key)
  );

endmodule
